FILE: rtl/klim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klim_pkg
// Shared constants, codes and types of the keyed connection limiter.
// ----------------------------------------------------------------------------
package klim_pkg;

  // table geometry
  localparam int ENTRIES = 64;
  localparam int AW      = $clog2(ENTRIES);

  // field widths
  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 16;
  localparam int STAT_W  = 3;

  // stream packing
  localparam int IN_TDATA_W  = 40;  // key, slot, zero fill
  localparam int IN_TUSER_W  = 2;   // action, key_present
  localparam int OUT_TDATA_W = 24;  // slot_used, count_after, entry_freed, zero fill
  localparam int OUT_TUSER_W = STAT_W;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_RUN    = 1'b1;

  // actions
  localparam logic ACT_ADMIT   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_SKIPPED      = 3'd0;
  localparam logic [STAT_W-1:0] ST_PASSED       = 3'd1;
  localparam logic [STAT_W-1:0] ST_REJECTED     = 3'd2;
  localparam logic [STAT_W-1:0] ST_REJECTED_DRY = 3'd3;
  localparam logic [STAT_W-1:0] ST_RELEASED     = 3'd4;
  localparam logic [STAT_W-1:0] ST_FREE_SLOT    = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] conn_limit;
    logic             dry_run;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic              key_present;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_used;
    logic [CNT_W-1:0]  count_after;
    logic              entry_freed;
  } res_t;

  // one table row: key and open-connection count
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/klim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module klim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/klim_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klim_seq
// Table sequencer: linear key search over the slot RAM, update and release.
// ----------------------------------------------------------------------------
module klim_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  klim_pkg::req_t item,
  input  klim_pkg::cfg_t cfg,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_ready,
  output klim_pkg::res_t res
);
  import klim_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_REL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  req_t            req_r;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   free_r, free_nxt;
  logic            have_free_r, have_free_nxt;
  res_t            res_r, res_nxt;
  logic [ENTRIES-1:0] valid_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  entry_t          rd;

  logic [CNT_W-1:0]  ent_cnt;
  logic              key_hit;
  logic              free_hit;
  logic              last;
  logic              slot_ok;
  logic [STAT_W-1:0] rej_code;
  logic [CNT_W-1:0]  dec_cnt;

  klim_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // rows never written read as free
  assign ent_cnt  = valid_r[cur_r] ? rd.cnt : '0;
  assign key_hit  = (ent_cnt != '0) && (rd.key == req_r.key);
  assign free_hit = (ent_cnt == '0) && !have_free_r;
  assign last     = (cur_r == AW'(ENTRIES - 1));
  assign slot_ok  = (32'(req_r.slot) < ENTRIES);
  assign rej_code = cfg.dry_run ? ST_REJECTED_DRY : ST_REJECTED;
  assign dec_cnt  = ent_cnt - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    free_nxt      = free_r;
    have_free_nxt = have_free_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = rd;
    ram_raddr     = cur_r + AW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (item.action == ACT_RELEASE) begin
          ram_raddr = AW'(item.slot);
        end else begin
          ram_raddr = '0;
        end
        if (start) begin
          res_nxt = '0;
          if (item.action == ACT_RELEASE) begin
            cur_nxt   = AW'(item.slot);
            state_nxt = S_REL;
          end else if (item.key_present) begin
            cur_nxt       = '0;
            have_free_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end else begin
            res_nxt.status = ST_SKIPPED;
            state_nxt      = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (key_hit) begin
          res_nxt.slot_used = SLOT_W'(cur_r);
          if (ent_cnt >= cfg.conn_limit) begin
            res_nxt.status      = rej_code;
            res_nxt.count_after = ent_cnt;
          end else begin
            ram_we              = 1'b1;
            ram_wdata.cnt       = ent_cnt + CNT_W'(1);
            res_nxt.status      = ST_PASSED;
            res_nxt.count_after = ent_cnt + CNT_W'(1);
          end
          state_nxt = S_DONE;
        end else begin
          if (free_hit) begin
            have_free_nxt = 1'b1;
            free_nxt      = cur_r;
          end
          if (last) begin
            if (have_free_r || free_hit) begin
              ram_we              = 1'b1;
              ram_waddr           = have_free_r ? free_r : cur_r;
              ram_wdata.key       = req_r.key;
              ram_wdata.cnt       = CNT_W'(1);
              res_nxt.status      = ST_PASSED;
              res_nxt.slot_used   = SLOT_W'(have_free_r ? free_r : cur_r);
              res_nxt.count_after = CNT_W'(1);
            end else begin
              res_nxt.status = rej_code;
            end
            state_nxt = S_DONE;
          end else begin
            cur_nxt = cur_r + AW'(1);
          end
        end
      end

      S_REL: begin
        res_nxt.slot_used = req_r.slot;
        if (!slot_ok || ent_cnt == '0) begin
          res_nxt.status = ST_FREE_SLOT;
        end else begin
          ram_we              = 1'b1;
          ram_wdata.cnt       = dec_cnt;
          res_nxt.status      = ST_RELEASED;
          res_nxt.count_after = dec_cnt;
          res_nxt.entry_freed = (dec_cnt == '0);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_free_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      have_free_r <= have_free_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= item;
    end
    cur_r  <= cur_nxt;
    free_r <= free_nxt;
    res_r  <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

FILE: rtl/keyed_connection_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_connection_limiter
// Per-key concurrent connection limit table with admit and release items.
// ----------------------------------------------------------------------------
// Flow: an admit reads the table RAM one slot after another, in order, up to the
//   first slot holding its key; a release reads only its own slot, a skipped admit none.
// Throughput: one item at a time; an admit holds the block until its scan is done,
//   bound by the single read port of the slot RAM.
// Reset: synchronous, active low; limit 1, dry run off, all slots free at once
//   through per-slot valid flops, no clearing pass.
module keyed_connection_limiter (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [klim_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [klim_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [klim_pkg::IN_TDATA_W-1:0]  in_tdata,   // key[31:0], slot[37:32]
  input  logic [klim_pkg::IN_TUSER_W-1:0]  in_tuser,   // action[0], key_present[1]
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [klim_pkg::OUT_TDATA_W-1:0] out_tdata,  // slot_used[5:0],
                                                       // count_after[21:6],
                                                       // entry_freed[22]
  output logic [klim_pkg::OUT_TUSER_W-1:0] out_tuser   // status[2:0]
);
  import klim_pkg::*;

  cfg_t  cfg_r;
  req_t  item;
  logic  start;
  logic  seq_idle;
  logic  res_valid;
  logic  res_ready;
  res_t  res;
  logic  out_valid_r;
  res_t  out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conn_limit <= CNT_W'(1);
      cfg_r.dry_run    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONN_LIMIT: cfg_r.conn_limit <= cfg_wdata[CNT_W-1:0];
        REG_DRY_RUN:    cfg_r.dry_run    <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  assign item.action      = in_tuser[0];
  assign item.key_present = in_tuser[1];
  assign item.key         = in_tdata[KEY_W-1:0];
  assign item.slot        = in_tdata[KEY_W+SLOT_W-1:KEY_W];

  assign in_tready = seq_idle;
  assign start     = in_tvalid && seq_idle;

  klim_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .cfg       (cfg_r),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register; frees while the sequencer works on the next item
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {(OUT_TDATA_W - SLOT_W - CNT_W - 1)'(0),
                       out_res_r.entry_freed,
                       out_res_r.count_after,
                       out_res_r.slot_used};

endmodule

FILE: tb/sv/tb_keyed_connection_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_connection_limiter
// Self-checking bench for the keyed connection limiter. A short directed
// sequence covers empty keys, hits at the limit, the zero limit, dry run and
// releases of free and busy slots. Random phases follow under several limit
// and dry-run settings, with key pools of several sizes, some large enough
// to fill the table. A table tracker predicts every verdict, and the results
// are compared field by field in order. Bursty sending, receiver stalls and
// one long receiver hold-off are included.
// ----------------------------------------------------------------------------
module tb_keyed_connection_limiter;
  import klim_pkg::*;

  localparam int TRACK_DUT   = 0;   // tracker advanced on accepted transfers
  localparam int TRACK_GEN   = 1;   // tracker advanced while building stimulus
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_CAP   = 100;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  keyed_connection_limiter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // two copies of the connection table: one follows the block, one plans
  logic [KEY_W-1:0] slot_key [2][ENTRIES];
  logic [CNT_W-1:0] slot_cnt [2][ENTRIES];
  logic [CNT_W-1:0] limit_cfg [2];
  logic             dry_cfg [2];

  req_t conn_events[$];
  res_t pending_verdicts[$];
  logic [KEY_W-1:0] key_pool [128];

  int mismatches = 0;
  int idle_cycles = 0;
  int hold_tok = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_tick = 0;
  int burst_left = 1;
  int gap_left = 0;
  req_t offered;
  res_t got_verdict;
  res_t want_verdict;

  function automatic res_t limit_step(input int t, input req_t r);
    res_t v;
    int i;
    int hit;
    int hole;
    logic [STAT_W-1:0] refuse;
    v = '0;
    hit = -1;
    hole = -1;
    refuse = dry_cfg[t] ? ST_REJECTED_DRY : ST_REJECTED;
    if (r.action == ACT_RELEASE) begin
      v.slot_used = r.slot;
      if (slot_cnt[t][r.slot] == '0) begin
        v.status = ST_FREE_SLOT;
      end else begin
        slot_cnt[t][r.slot] = slot_cnt[t][r.slot] - CNT_W'(1);
        v.status      = ST_RELEASED;
        v.count_after = slot_cnt[t][r.slot];
        v.entry_freed = (slot_cnt[t][r.slot] == '0);
      end
    end else if (r.key_present) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (slot_cnt[t][i] != '0) begin
          if (hit < 0 && slot_key[t][i] == r.key) hit = i;
        end else if (hole < 0) begin
          hole = i;
        end
      end
      if (hit >= 0) begin
        v.slot_used = SLOT_W'(hit);
        if (slot_cnt[t][hit] >= limit_cfg[t]) begin
          v.status = refuse;
        end else begin
          slot_cnt[t][hit] = slot_cnt[t][hit] + CNT_W'(1);
          v.status = ST_PASSED;
        end
        v.count_after = slot_cnt[t][hit];
      end else if (hole >= 0) begin
        slot_key[t][hole] = r.key;
        slot_cnt[t][hole] = CNT_W'(1);
        v.status      = ST_PASSED;
        v.slot_used   = SLOT_W'(hole);
        v.count_after = CNT_W'(1);
      end else begin
        v.status = refuse;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // ---- sender: bursts with random gaps, tracker advanced on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        pending_verdicts.push_back(limit_step(TRACK_DUT, offered));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (conn_events.size() > 0) begin
          offered = conn_events.pop_front();
          in_tdata  <= {2'b00, offered.slot, offered.key};
          in_tuser  <= {offered.key_present, offered.action};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver: stall mode changes now and then; long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick = rx_tick + 1;
      if (hold_tok != hold_ack) begin
        hold_ack  = hold_tok;
        hold_left = LONG_HOLD;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left = rx_mode_left - 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  // ---- result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_verdict.status      = out_tuser;
      got_verdict.slot_used   = out_tdata[5:0];
      got_verdict.count_after = out_tdata[21:6];
      got_verdict.entry_freed = out_tdata[22];
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, status", int'(got_verdict.status), 0);
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (got_verdict.status != want_verdict.status)
          report_mismatch("status", int'(got_verdict.status),
                          int'(want_verdict.status));
        if (got_verdict.slot_used != want_verdict.slot_used)
          report_mismatch("slot_used", int'(got_verdict.slot_used),
                          int'(want_verdict.slot_used));
        if (got_verdict.count_after != want_verdict.count_after)
          report_mismatch("count_after", int'(got_verdict.count_after),
                          int'(want_verdict.count_after));
        if (got_verdict.entry_freed != want_verdict.entry_freed)
          report_mismatch("entry_freed", int'(got_verdict.entry_freed),
                          int'(want_verdict.entry_freed));
      end
    end
  end

  // ---- watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_event(input logic act, input logic [KEY_W-1:0] key,
                             input logic present, input logic [SLOT_W-1:0] slot);
    req_t r;
    r.action      = act;
    r.key         = key;
    r.key_present = present;
    r.slot        = slot;
    void'(limit_step(TRACK_GEN, r));
    conn_events.push_back(r);
  endtask

  task automatic queue_admit(input logic [KEY_W-1:0] key, input logic present);
    queue_event(ACT_ADMIT, key, present, SLOT_W'($urandom()));
  endtask

  task automatic queue_release(input logic [SLOT_W-1:0] slot);
    queue_event(ACT_RELEASE, KEY_W'($urandom()), 1'($urandom_range(0, 1)), slot);
  endtask

  // block drained: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (conn_events.size() != 0 || in_tvalid || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [CNT_W-1:0] limit, input logic dry);
    int t;
    write_reg(REG_CONN_LIMIT, limit);
    write_reg(REG_DRY_RUN, {{(CFG_DATA_W-1){1'b0}}, dry});
    for (t = 0; t < 2; t++) begin
      limit_cfg[t] = limit;
      dry_cfg[t]   = dry;
    end
  endtask

  // mostly pool keys so hits, limits and a full table all come up
  task automatic queue_random(input int pool_sz, input int rel_pct);
    int pick;
    int i;
    int busy[$];
    pick = $urandom_range(0, 99);
    if (pick < rel_pct) begin
      for (i = 0; i < ENTRIES; i++)
        if (slot_cnt[TRACK_GEN][i] != '0) busy.push_back(i);
      if (busy.size() > 0 && $urandom_range(0, 3) != 0)
        queue_release(SLOT_W'(busy[$urandom_range(0, busy.size() - 1)]));
      else
        queue_release(SLOT_W'($urandom()));
    end else if (pick < rel_pct + 5) begin
      queue_admit($urandom(), 1'b0);
    end else if (pick < rel_pct + 12) begin
      queue_admit($urandom(), 1'b1);
    end else begin
      queue_admit(key_pool[$urandom_range(0, pool_sz - 1)], 1'b1);
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] limit, input logic dry, input int n,
                           input int pool_sz, input int rel_pct, input bit long_hold);
    int i;
    set_config(limit, dry);
    // every fourth key differs from its neighbor in a single bit
    for (i = 0; i < 128; i++)
      key_pool[i] = (i % 4 == 3) ? key_pool[i-1] ^ (32'h1 << $urandom_range(0, 31))
                                 : KEY_W'($urandom());
    if (long_hold) hold_tok = hold_tok + 1;
    for (i = 0; i < n; i++)
      queue_random(pool_sz, rel_pct);
    wait_idle();
  endtask

  initial begin
    int t;
    int i;
    for (t = 0; t < 2; t++) begin
      for (i = 0; i < ENTRIES; i++) begin
        slot_key[t][i] = '0;
        slot_cnt[t][i] = '0;
      end
      limit_cfg[t] = CNT_W'(1);
      dry_cfg[t]   = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: limit 1, no dry run
    queue_release(6'd0);                  // free slot
    queue_release(6'd63);
    queue_admit(32'hFFFF_FFFF, 1'b0);     // empty key
    queue_admit(32'h0000_0000, 1'b1);
    queue_admit(32'h0000_0000, 1'b1);     // at limit
    queue_admit(32'hFFFF_FFFF, 1'b1);
    queue_admit(32'h8000_0000, 1'b1);
    queue_release(6'd1);                  // back to zero, slot freed
    queue_admit(32'h0000_0001, 1'b1);     // reuses lowest free slot
    queue_admit(32'h0000_0001, 1'b1);
    queue_release(6'd0);
    queue_release(6'd0);
    wait_idle();

    // zero limit with dry run: found keys refused, new keys still placed
    set_config(16'd0, 1'b1);
    queue_admit(32'h8000_0000, 1'b1);
    queue_admit(32'hDEAD_BEEF, 1'b1);
    queue_admit(32'hDEAD_BEEF, 1'b1);
    wait_idle();

    set_config(16'hFFFF, 1'b0);
    queue_admit(32'hDEAD_BEEF, 1'b1);
    queue_admit(32'hDEAD_BEEF, 1'b1);
    queue_admit(32'hDEAD_BEEF, 1'b1);
    queue_release(6'd0);                  // count drops, slot stays busy
    queue_release(6'd2);
    wait_idle();

    run_phase(16'd2,    1'b0, 200, 12,  35, 1'b0);
    run_phase(16'd3,    1'b0, 250, 120, 8,  1'b1);  // fills the table
    run_phase(16'd3,    1'b1, 150, 120, 8,  1'b0);  // full table, dry run
    run_phase(16'hFFFF, 1'b1, 100, 20,  40, 1'b0);
    run_phase(16'hFFFF, 1'b1, 100, 20,  40, 1'b0);
    run_phase(16'd0,    1'b0, 150, 30,  45, 1'b0);
    run_phase(16'd1,    1'b1, 200, 40,  40, 1'b0);

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
